[hw/rtl/recursive_mutex_table_defines.svh]
// Assertion macros shared by the mutex table RTL.
`ifndef RECURSIVE_MUTEX_TABLE_DEFINES_SVH
`define RECURSIVE_MUTEX_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RMT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mutex table assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mutex table assertion failed");

`endif

[hw/rtl/rmt_pkg.sv]
// Package with the operation codes, status codes and slot entry type of the mutex table.
`timescale 1ns / 1ps
package rmt_pkg;

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_DESTROY = 3'd1;
  localparam logic [2:0] OP_LOCK    = 3'd2;
  localparam logic [2:0] OP_TRYLOCK = 3'd3;
  localparam logic [2:0] OP_UNLOCK  = 3'd4;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_SUCH      = 3'd1;
  localparam logic [2:0] ST_OUT_OF_SLOTS = 3'd2;
  localparam logic [2:0] ST_DEADLOCK     = 3'd3;
  localparam logic [2:0] ST_BUSY         = 3'd4;
  localparam logic [2:0] ST_PERM         = 3'd5;
  localparam logic [2:0] ST_WAIT         = 3'd6;
  localparam logic [2:0] ST_COUNT_FULL   = 3'd7;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam int IN_BYTES_W  = 72;
  localparam int OUT_BYTES_W = 16;

  typedef struct packed {
    logic        active;
    logic        recursive;
    logic [31:0] owner;
    logic [15:0] count;
  } entry_t;

endpackage

[hw/rtl/rmt_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module rmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/recursive_mutex_table.sv]
// Lock table: a small sequencer around one slot RAM that serves create, destroy,
// lock, trylock and unlock requests.
//
// The slave channel takes one request word; the master channel returns one
// status word per request. A request is taken only while the sequencer is idle.
// Destroy, lock, trylock and unlock read the slot in the accept cycle and update
// it in the evaluation state once the output register is free. Create scans the
// slot RAM from slot 0 one entry per cycle until it finds the lowest free slot,
// or up to the last slot when the table is full; the single RAM read port sets
// this pace.
// The result sits in an output register, so a new request is accepted while an
// earlier status word still waits. When the receiver stalls and that register
// is still full, the sequencer holds its finished request until it drains.
// After reset the RAM is cleared one slot per cycle, and no request is accepted
// during that pass.
`timescale 1ns / 1ps
`include "recursive_mutex_table_defines.svh"
module recursive_mutex_table #(
  parameter int SLOTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // mode[2:0], lock_id[34:3], caller_thread[66:35], want_recursive[67], zero pad
  input  logic [rmt_pkg::IN_BYTES_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status[2:0], new_id[9:3], zero pad
  output logic [rmt_pkg::OUT_BYTES_W-1:0] out_tdata
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam int ENTRY_W = $bits(rmt_pkg::entry_t);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_SCAN
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic              id_ok_r, id_ok_nxt;
  logic [31:0]       who_r, who_nxt;
  logic              rec_r, rec_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [6:0]        out_new_id_r, out_new_id_nxt;

  logic [2:0]        in_mode;
  logic [31:0]       in_lock_id;
  logic [31:0]       in_caller;
  logic              in_want_rec;
  logic [31:0]       id_m1;
  logic [IDX_W-1:0]  in_slot;
  logic              in_id_ok;
  logic              in_acc;
  logic              out_free;
  logic              out_load;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [IDX_W-1:0]    ram_raddr;
  rmt_pkg::entry_t     ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  rmt_pkg::entry_t     cur;

  logic                owner_hit;
  logic [31:0]         scan_id;
  logic [2:0]          eval_status;
  rmt_pkg::entry_t     eval_entry;
  logic                eval_hit;

  rmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_mode     = in_tdata[2:0];
  assign in_lock_id  = in_tdata[34:3];
  assign in_caller   = in_tdata[66:35];
  assign in_want_rec = in_tdata[67];
  assign id_m1       = in_lock_id - 32'd1;
  assign in_slot     = id_m1[IDX_W-1:0];
  assign in_id_ok    = (in_lock_id != 32'd0) && (in_lock_id <= 32'(SLOTS));

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign cur       = rmt_pkg::entry_t'(ram_rdata);
  assign owner_hit = (cur.owner == who_r);
  assign scan_id   = 32'(scan_idx_r) + 32'd1;
  assign eval_hit  = id_ok_r && cur.active;

  // Outcome of one read-modify-write on the addressed slot.
  always_comb begin
    eval_status = rmt_pkg::ST_NO_SUCH;
    eval_entry  = cur;
    if (eval_hit) begin
      case (mode_r) inside
        rmt_pkg::OP_DESTROY: begin
          eval_entry.active = 1'b0;
          eval_status       = rmt_pkg::ST_OK;
        end
        rmt_pkg::OP_LOCK, rmt_pkg::OP_TRYLOCK: begin
          if (cur.count != 16'd0 && owner_hit) begin
            if (!cur.recursive) begin
              eval_status = (mode_r == rmt_pkg::OP_LOCK) ? rmt_pkg::ST_DEADLOCK
                                                         : rmt_pkg::ST_BUSY;
            end else if (cur.count == rmt_pkg::COUNT_MAX) begin
              eval_status = rmt_pkg::ST_COUNT_FULL;
            end else begin
              eval_entry.count = cur.count + 16'd1;
              eval_status      = rmt_pkg::ST_OK;
            end
          end else if (cur.count != 16'd0) begin
            eval_status = (mode_r == rmt_pkg::OP_LOCK) ? rmt_pkg::ST_WAIT
                                                       : rmt_pkg::ST_BUSY;
          end else begin
            eval_entry.owner = who_r;
            eval_entry.count = 16'd1;
            eval_status      = rmt_pkg::ST_OK;
          end
        end
        rmt_pkg::OP_UNLOCK: begin
          if (!owner_hit || cur.count == 16'd0) begin
            eval_status = rmt_pkg::ST_PERM;
          end else begin
            eval_entry.count = cur.count - 16'd1;
            if (cur.count == 16'd1) begin
              eval_entry.owner = 32'd0;
            end
            eval_status = rmt_pkg::ST_OK;
          end
        end
        default: begin
          eval_status = rmt_pkg::ST_NO_SUCH;
        end
      endcase
    end
  end

  // Sequencer: next state, RAM port control and result register loading.
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    scan_idx_nxt   = scan_idx_r;
    slot_nxt       = slot_r;
    mode_nxt       = mode_r;
    id_ok_nxt      = id_ok_r;
    who_nxt        = who_r;
    rec_nxt        = rec_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_new_id_nxt = out_new_id_r;
    out_load       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = slot_r;
    ram_wdata      = eval_entry;
    ram_raddr      = slot_r;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '0;
        ram_raddr = '0;
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = (in_mode == rmt_pkg::OP_CREATE) ? '0 : in_slot;
        if (in_acc) begin
          mode_nxt     = in_mode;
          slot_nxt     = in_slot;
          id_ok_nxt    = in_id_ok;
          who_nxt      = in_caller;
          rec_nxt      = in_want_rec;
          scan_idx_nxt = '0;
          state_nxt    = (in_mode == rmt_pkg::OP_CREATE) ? S_SCAN : S_EVAL;
        end
      end
      S_EVAL: begin
        ram_raddr = slot_r;
        if (out_free) begin
          out_load       = 1'b1;
          out_tvalid_nxt = 1'b1;
          out_status_nxt = eval_status;
          out_new_id_nxt = 7'd0;
          ram_we         = eval_hit;
          ram_waddr      = slot_r;
          ram_wdata      = eval_entry;
          state_nxt      = S_IDLE;
        end
      end
      S_SCAN: begin
        ram_raddr = scan_idx_r;
        if (!cur.active) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_tvalid_nxt = 1'b1;
            out_status_nxt = rmt_pkg::ST_OK;
            out_new_id_nxt = scan_id[6:0];
            ram_we         = 1'b1;
            ram_waddr      = scan_idx_r;
            ram_wdata      = '{active: 1'b1, recursive: rec_r, owner: 32'd0, count: 16'd0};
            state_nxt      = S_IDLE;
          end
        end else if (scan_idx_r == LAST_IDX) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_tvalid_nxt = 1'b1;
            out_status_nxt = rmt_pkg::ST_OUT_OF_SLOTS;
            out_new_id_nxt = 7'd0;
            state_nxt      = S_IDLE;
          end
        end else begin
          // Issue the read of the following slot while this one is checked.
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
          ram_raddr    = scan_idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    scan_idx_r   <= scan_idx_nxt;
    slot_r       <= slot_nxt;
    mode_r       <= mode_nxt;
    id_ok_r      <= id_ok_nxt;
    who_r        <= who_nxt;
    rec_r        <= rec_nxt;
    out_status_r <= out_status_nxt;
    out_new_id_r <= out_new_id_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_new_id_r, out_status_r};

  `RMT_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready)
  `RMT_ASSERT_NOW(a_load_only_when_done, out_load,
    (state_r == S_EVAL) || (state_r == S_SCAN))
  `RMT_ASSERT_NOW(a_no_result_in_clear, state_r == S_CLEAR, !out_tvalid)
  `RMT_ASSERT_NOW(a_new_id_only_create, out_load && (state_r == S_EVAL),
    out_new_id_nxt == 7'd0)

endmodule
